// ===== hdl/tdpbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Tail-drop packet buffer scheduler package
// Shared widths, constants, controller states and the cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpbs_pkg;

  localparam int TIME_W = 32;
  localparam int ARR_W  = 20;
  localparam int PROC_W = 10;
  localparam int CFG_W  = 9;

  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [CFG_W-1:0]  CFG_RESET = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/tdpbs_cell.sv =====
// ----------------------------------------------------------------------------
// Finish-time cell
// One entry of the finish-time queue: loads a new finish time or takes the
// value of its neighbour further from the head when the queue advances.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpbs_cell
  import tdpbs_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [TIME_W-1:0] load_data,
  input  wire logic [TIME_W-1:0] shift_data,
  output logic      [TIME_W-1:0] data
);

  logic [TIME_W-1:0] data_r;
  logic [TIME_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = shift_data;
    end else if (ctrl.load) begin
      data_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== hdl/tail_drop_packet_buffer_scheduler.sv =====
// ----------------------------------------------------------------------------
// Tail-drop packet buffer scheduler
// Schedules packet arrivals onto one processor behind a bounded buffer.
// ----------------------------------------------------------------------------
// Each arrival beat retires every held packet whose finish time is at or
// before its arrival, then is either dropped (buffer full) or given a start
// time at the later of its arrival and the previous finish time, with the
// finish time saturating at the maximum. Finish times sit in a row of cells
// with the oldest in cell 0; the row moves one place towards the head per
// retired packet. An item is accepted, then retires its packets one at a
// time, then finds the head still held or the row empty and is decided; the
// decision waits while a result beat is stalled, and no new item is accepted
// until it is made. There is no clearing pass after reset. The buffer size
// register may only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tail_drop_packet_buffer_scheduler
  import tdpbs_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ARR_W-1:0]  in_arrival_time,
  input  wire logic [PROC_W-1:0] in_process_time,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_dropped,
  output logic      [TIME_W-1:0] out_start_time,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_buffer_size
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  state_t state_r, state_nxt;

  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [TIME_W-1:0] last_finish_r, last_finish_nxt;
  logic [CFG_W-1:0]  buffer_size_r, buffer_size_nxt;
  logic [ARR_W-1:0]  arr_r, arr_nxt;
  logic [PROC_W-1:0] proc_r, proc_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_dropped_r, out_dropped_nxt;
  logic [TIME_W-1:0] out_start_r, out_start_nxt;

  logic [TIME_W-1:0] cell_q [DEPTH];
  logic              shift;
  logic              push;
  logic              drop;
  logic [TIME_W-1:0] arr_ext;
  logic [TIME_W-1:0] start;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] finish;
  logic [CMP_W-1:0]  size_ext;
  logic [CMP_W-1:0]  cap;

  assign arr_ext  = {{(TIME_W-ARR_W){1'b0}}, arr_r};
  assign start    = (last_finish_r > arr_ext) ? last_finish_r : arr_ext;
  assign sum      = {1'b0, start} + {{(TIME_W+1-PROC_W){1'b0}}, proc_r};
  assign finish   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign size_ext = CMP_W'(buffer_size_r);
  assign cap      = (size_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : size_ext;
  assign drop     = CMP_W'(occ_r) >= cap;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cell_ctrl_t        ctrl;
      logic [TIME_W-1:0] next_q;

      assign ctrl = '{shift, push && (occ_r == OCC_W'(gi))};

      if (gi < DEPTH - 1) begin : g_mid
        assign next_q = cell_q[gi+1];
      end else begin : g_last
        assign next_q = '0;
      end

      tdpbs_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .load_data  (finish),
        .shift_data (next_q),
        .data       (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    shift           = 1'b0;
    push            = 1'b0;
    arr_nxt         = arr_r;
    proc_nxt        = proc_r;
    out_dropped_nxt = out_dropped_r;
    out_start_nxt   = out_start_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          arr_nxt   = in_arrival_time;
          proc_nxt  = in_process_time;
          state_nxt = ST_RETIRE;
        end
      end
      ST_RETIRE: begin
        if ((occ_r != '0) && (cell_q[0] <= arr_ext)) begin
          shift = 1'b1;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_dropped_nxt = drop;
          out_start_nxt   = drop ? '0 : start;
          push            = !drop;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    occ_nxt         = occ_r;
    last_finish_nxt = last_finish_r;
    if (shift) begin
      occ_nxt = occ_r - OCC_W'(1);
    end else if (push) begin
      occ_nxt         = occ_r + OCC_W'(1);
      last_finish_nxt = finish;
    end
    buffer_size_nxt = cfg_valid ? cfg_buffer_size : buffer_size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      occ_r         <= '0;
      last_finish_r <= '0;
      buffer_size_r <= CFG_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      occ_r         <= occ_nxt;
      last_finish_r <= last_finish_nxt;
      buffer_size_r <= buffer_size_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arr_r         <= arr_nxt;
    proc_r        <= proc_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_start_r   <= out_start_nxt;
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_dropped    = out_dropped_r;
  assign out_start_time = out_start_r;

endmodule

`default_nettype wire

// ===== hdl/tdpbs_checker.sv =====
// ----------------------------------------------------------------------------
// Tail-drop packet buffer scheduler checker
// Port-level assertions on the scheduler, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpbs_checker
  import tdpbs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [ARR_W-1:0]  in_arrival_time,
  input wire logic [PROC_W-1:0] in_process_time,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_dropped,
  input wire logic [TIME_W-1:0] out_start_time,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready,
  input wire logic [CFG_W-1:0]  cfg_buffer_size
);

  // A dropped packet never reports a start time.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (out_start_time == '0))
    else $error("dropped beat carries a non-zero start time");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_dropped) && $stable(out_start_time)))
    else $error("stalled result beat changed");

  // One item at a time: the input closes straight after a beat is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted a second beat while busy");

  // An item's result cannot appear before the item has passed the retire and decide states.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared one cycle after its input beat");

endmodule

bind tail_drop_packet_buffer_scheduler tdpbs_checker u_tdpbs_checker (.*);

`default_nettype wire

// ===== tb/sv/tail_drop_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail-drop scheduler checker
// Watches the arrival, result and buffer size channels of the scheduler. It
// keeps its own copy of the held finish times and the last finish time, and
// works out the verdict for every accepted arrival beat. Each result beat is
// compared, field by field, with the oldest verdict still outstanding.
// ----------------------------------------------------------------------------
module tail_drop_checker
  import tdpbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [ARR_W-1:0]  in_arrival_time,
  input  logic [PROC_W-1:0] in_process_time,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_dropped,
  input  logic [TIME_W-1:0] out_start_time,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_buffer_size,
  output int                failures,
  output int                pending
);

  localparam int SLOTS = 256;

  typedef struct packed {
    logic              dropped;
    logic [TIME_W-1:0] begin_ms;
  } verdict_t;

  logic [TIME_W-1:0] held_finish[$];
  logic [TIME_W-1:0] prev_finish;
  logic [CFG_W-1:0]  size_reg;
  verdict_t          expected_verdicts[$];
  int                fail_count = 0;

  function automatic verdict_t schedule_arrival(input logic [ARR_W-1:0] arr,
                                                input logic [PROC_W-1:0] ptime);
    verdict_t          v;
    int                cap;
    logic [TIME_W-1:0] arr_t;
    logic [TIME_W:0]   sum;
    cap   = (size_reg > SLOTS) ? SLOTS : int'(size_reg);
    arr_t = TIME_W'(arr);
    while (held_finish.size() > 0 && held_finish[0] <= arr_t)
      void'(held_finish.pop_front());
    if (held_finish.size() >= cap) begin
      v.dropped  = 1'b1;
      v.begin_ms = '0;
    end else begin
      v.dropped   = 1'b0;
      v.begin_ms  = (prev_finish > arr_t) ? prev_finish : arr_t;
      sum         = {1'b0, v.begin_ms} + (TIME_W+1)'(ptime);
      prev_finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      held_finish.insert(held_finish.size(), prev_finish);
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      held_finish.delete();
      expected_verdicts.delete();
      prev_finish = '0;
      size_reg    = CFG_RESET;
    end else begin
      if (cfg_valid && cfg_ready)
        size_reg = cfg_buffer_size;
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result beat: dropped %0d out_start_time %0d",
                 out_dropped, out_start_time);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_dropped !== want.dropped) begin
            $error("dropped: expected %0d, actual %0d", want.dropped, out_dropped);
            fail_count++;
          end
          if (out_start_time !== want.begin_ms) begin
            $error("out_start_time: expected %0d, actual %0d",
                   want.begin_ms, out_start_time);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_verdicts.insert(expected_verdicts.size(),
                                 schedule_arrival(in_arrival_time, in_process_time));
    end
    failures <= fail_count;
    pending  <= expected_verdicts.size();
  end

endmodule

// ===== tb/sv/tail_drop_packet_buffer_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail-drop packet buffer scheduler testbench
// Drives packet arrival beats through a directed opening, random traffic
// phases under several buffer sizes and a directed close at the top of the
// time range. Both sides idle at random, and the result side holds off once
// for a long stretch so that the block backs up. The checker does the rest.
// ----------------------------------------------------------------------------
module tail_drop_packet_buffer_scheduler_tb;
  import tdpbs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 80;
  localparam int HOLD_CYCLES = 400;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [ARR_W-1:0]  in_arrival_time;
  logic [PROC_W-1:0] in_process_time;
  logic              out_valid;
  logic              out_ready;
  logic              out_dropped;
  logic [TIME_W-1:0] out_start_time;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_buffer_size;

  int failures;
  int pending;
  int cycles = 0;
  int time_base;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;

  tail_drop_packet_buffer_scheduler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_arrival_time (in_arrival_time),
    .in_process_time (in_process_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dropped     (out_dropped),
    .out_start_time  (out_start_time),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_buffer_size (cfg_buffer_size)
  );

  tail_drop_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_arrival_time (in_arrival_time),
    .in_process_time (in_process_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dropped     (out_dropped),
    .out_start_time  (out_start_time),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_buffer_size (cfg_buffer_size),
    .failures        (failures),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_packet(input logic [ARR_W-1:0] arr, input logic [PROC_W-1:0] ptime);
    int gap;
    if ($urandom_range(0, 39) == 0)
      quiet_tx = !quiet_tx;
    gap = quiet_tx ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_arrival_time <= arr;
    in_process_time <= ptime;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic write_buffer_size(input logic [CFG_W-1:0] size);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_valid       <= 1'b1;
    cfg_buffer_size <= size;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_traffic(input logic [CFG_W-1:0] size, input int count, input bit heavy);
    int               step_ms;
    logic [ARR_W-1:0] arr;
    logic [PROC_W-1:0] ptime;
    write_buffer_size(size);
    repeat (count) begin
      if (heavy || $urandom_range(0, 9) < 7)
        step_ms = $urandom_range(0, heavy ? 15 : 63);
      else
        step_ms = $urandom_range(0, 16000);
      time_base = (time_base + step_ms > 20'hFFFFF) ? 20'hFFFFF : time_base + step_ms;
      arr = ARR_W'(time_base);
      if ($urandom_range(0, 32) == 0)
        arr = (time_base > 2000) ? ARR_W'(time_base - $urandom_range(0, 2000)) : '0;
      ptime = heavy ? PROC_W'($urandom_range(256, 1023)) : PROC_W'($urandom());
      send_packet(arr, ptime);
    end
  endtask

  initial begin
    int wait_cycles;
    int results_taken;
    results_taken = 0;
    out_ready     = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0)
        quiet_rx = !quiet_rx;
      wait_cycles = quiet_rx ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_taken++;
      if (results_taken == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_arrival_time = '0;
    in_process_time = '0;
    cfg_valid       = 1'b0;
    cfg_buffer_size = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Opening: reset size, a two-deep buffer, zero size, oversize, and a
    // one-deep buffer, with arrivals that go backwards now and then.
    send_packet(20'd0, 10'd0);
    send_packet(20'd0, 10'd1023);
    write_buffer_size(9'd2);
    send_packet(20'd0, 10'd1023);
    send_packet(20'd1, 10'd5);
    send_packet(20'd1023, 10'd0);
    send_packet(20'd5000, 10'd3);
    send_packet(20'd4000, 10'd7);
    write_buffer_size(9'd0);
    send_packet(20'd6000, 10'd1);
    send_packet(20'd6000, 10'd0);
    write_buffer_size(9'd511);
    send_packet(20'd6000, 10'd1023);
    send_packet(20'd6000, 10'd1023);
    send_packet(20'd6000, 10'd1023);
    send_packet(20'd6001, 10'd0);
    write_buffer_size(9'd1);
    send_packet(20'd20000, 10'h2AA);
    send_packet(20'd20000, 10'h155);
    send_packet(20'd25000, 10'h3FF);

    time_base = 30000;
    offer_traffic(9'd256, 140, 1'b1);
    offer_traffic(9'd2, 40, 1'b1);
    offer_traffic(9'd0, 20, 1'b0);
    offer_traffic(9'd511, 130, 1'b1);
    offer_traffic(9'd1, 40, 1'b0);
    offer_traffic(9'd300, 50, 1'b0);
    offer_traffic(9'd170, 40, 1'b0);
    offer_traffic(9'd85, 40, 1'b0);
    offer_traffic(9'd16, 50, 1'b1);

    // Closing: the top of the arrival range, patterned values, and a step back.
    write_buffer_size(9'd256);
    send_packet(20'h55555, 10'd1);
    send_packet(20'hAAAAA, 10'd2);
    send_packet(20'h80000, 10'd0);
    send_packet(20'hFFFFF, 10'd1023);
    send_packet(20'h7FFFF, 10'd512);
    send_packet(20'hFFFFF, 10'd0);
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
